// File: rtl/qrs_pkg.sv
`timescale 1ns / 1ps
package qrs_pkg;
  localparam int COEF_W  = 16;
  localparam int VAL_W   = 32;
  localparam int DMAG_W  = 34;   // magnitude of the discriminant
  localparam int ROOT_W  = 17;   // floor square root of the magnitude
  localparam int SQ_REM_W = 18;
  localparam int NUM_W   = 17;   // numerator magnitude
  localparam int DEN_W   = 17;   // 2|a|
  localparam int QUO_W   = NUM_W + 16;
  localparam int DV_REM_W = DEN_W + 1;
endpackage

// File: rtl/qrs_in_if.sv
`timescale 1ns / 1ps
interface qrs_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [qrs_pkg::COEF_W-1:0]   coef_a;
  logic signed [qrs_pkg::COEF_W-1:0]   coef_b;
  logic signed [qrs_pkg::COEF_W-1:0]   coef_c;
  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

// File: rtl/qrs_out_if.sv
`timescale 1ns / 1ps
interface qrs_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [qrs_pkg::VAL_W-1:0]   first_value;
  logic signed [qrs_pkg::VAL_W-1:0]   second_value;
  logic                               is_complex;
  logic                               divide_fault;
  logic                               saturated;
  modport source (output valid, first_value, second_value, is_complex, divide_fault,
                  saturated, input ready);
  modport sink   (input valid, first_value, second_value, is_complex, divide_fault,
                  saturated, output ready);
endinterface

// File: rtl/quadratic_root_solver.sv
`timescale 1ns / 1ps
// Quadratic root solver: a*x^2 + b*x + c = 0 in fixed point.
// Channel coef (sink) takes signed Q8.8 coefficients a, b, c; channel result
// (source) gives two Q16.16 values plus complex, divide-fault and saturation
// flags. Both use valid/ready; a transaction completes when both are high.
// Real roots: first = (-b+s)/2a, second = (-b-s)/2a. Complex: first = -b/2a,
// second = s/2a, where s is the floored square root of |b*b-4ac|.
// From coefficient transaction to result valid the pipe holds one multiply
// stage, one discriminant stage, 17 square-root stages (two bits each), one
// numerator stage, 33 divider stages (one quotient bit each, two dividers
// side by side) and the output register.
// Throughput is one transaction per cycle while the receiver does not stall.
// Reset clears every stage valid bit; the pipe is then empty and ready.
// When the receiver stalls with a result waiting, the whole pipe holds and
// coef.ready drops; nothing is lost or repeated.
module quadratic_root_solver (
  input logic        clk,
  input logic        rst,
  qrs_in_if.sink     coef,
  qrs_out_if.source  result
);
  localparam int SQ_N = qrs_pkg::ROOT_W;
  localparam int DV_N = qrs_pkg::QUO_W;

  logic en;
  assign en = !result.valid || result.ready;
  assign coef.ready = en;

  // full-width square of b; never negative and at most 2^30
  logic signed [31:0] bb_full;
  assign bb_full = coef.coef_b * coef.coef_b;

  // multiply stage
  logic        m_vld;
  logic [30:0] m_bb;
  logic signed [31:0] m_ac;
  logic signed [15:0] m_a, m_b;
  always_ff @(posedge clk) begin
    if (rst) m_vld <= 1'b0;
    else if (en) m_vld <= coef.valid;
    if (en) begin
      m_bb <= bb_full[30:0];
      m_ac <= coef.coef_a * coef.coef_c;
      m_a  <= coef.coef_a;
      m_b  <= coef.coef_b;
    end
  end

  // discriminant stage
  logic signed [34:0] d_val;
  assign d_val = $signed({4'b0, m_bb}) - ($signed({{3{m_ac[31]}}, m_ac}) <<< 2);
  logic        dd_vld, dd_cplx;
  logic [qrs_pkg::DMAG_W-1:0] dd_mag;
  logic signed [15:0] dd_a, dd_b;
  always_ff @(posedge clk) begin
    if (rst) dd_vld <= 1'b0;
    else if (en) dd_vld <= m_vld;
    if (en) begin
      dd_cplx <= d_val[34];
      dd_mag  <= d_val[34] ? qrs_pkg::DMAG_W'(-d_val) : qrs_pkg::DMAG_W'(d_val);
      dd_a    <= m_a;
      dd_b    <= m_b;
    end
  end

  // square-root stages, two bits of the radicand each
  logic                          sq_vld  [0:SQ_N];
  logic                          sq_cplx [0:SQ_N];
  logic [qrs_pkg::SQ_REM_W-1:0]  sq_rem  [0:SQ_N];
  logic [qrs_pkg::ROOT_W-1:0]    sq_root [0:SQ_N];
  logic [qrs_pkg::DMAG_W-1:0]    sq_v    [0:SQ_N];
  logic signed [15:0]            sq_a    [0:SQ_N];
  logic signed [15:0]            sq_b    [0:SQ_N];
  assign sq_vld[0]  = dd_vld;
  assign sq_cplx[0] = dd_cplx;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_v[0]    = dd_mag;
  assign sq_a[0]    = dd_a;
  assign sq_b[0]    = dd_b;

  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    logic [19:0] rem_sh, trial;
    logic        take;
    always_comb begin
      rem_sh = {sq_rem[k], sq_v[k][qrs_pkg::DMAG_W-1 -: 2]};
      trial  = {1'b0, sq_root[k], 2'b01};
      take   = rem_sh >= trial;
    end
    always_ff @(posedge clk) begin
      if (rst) sq_vld[k+1] <= 1'b0;
      else if (en) sq_vld[k+1] <= sq_vld[k];
      if (en) begin
        sq_rem[k+1]  <= take ? qrs_pkg::SQ_REM_W'(rem_sh - trial)
                             : qrs_pkg::SQ_REM_W'(rem_sh);
        sq_root[k+1] <= {sq_root[k][qrs_pkg::ROOT_W-2:0], take};
        sq_v[k+1]    <= sq_v[k] << 2;
        sq_cplx[k+1] <= sq_cplx[k];
        sq_a[k+1]    <= sq_a[k];
        sq_b[k+1]    <= sq_b[k];
      end
    end
  end

  // numerator stage: signs and magnitudes for both quotients
  logic signed [18:0] nb, ns, n1, n2;
  always_comb begin
    nb = -$signed({{3{sq_b[SQ_N][15]}}, sq_b[SQ_N]});
    ns = $signed({2'b0, sq_root[SQ_N]});
    n1 = sq_cplx[SQ_N] ? nb : nb + ns;
    n2 = sq_cplx[SQ_N] ? ns : nb - ns;
  end
  logic                     dv_vld   [0:DV_N];
  logic                     dv_cplx  [0:DV_N];
  logic                     dv_fault [0:DV_N];
  logic                     dv_neg1  [0:DV_N];
  logic                     dv_neg2  [0:DV_N];
  logic [qrs_pkg::DEN_W-1:0] dv_den  [0:DV_N];
  logic [qrs_pkg::DV_REM_W-1:0] dv_r1 [0:DV_N];
  logic [qrs_pkg::DV_REM_W-1:0] dv_r2 [0:DV_N];
  logic [qrs_pkg::QUO_W-1:0] dv_q1   [0:DV_N];
  logic [qrs_pkg::QUO_W-1:0] dv_q2   [0:DV_N];
  logic signed [16:0] a_ext;
  assign a_ext = $signed({sq_a[SQ_N][15], sq_a[SQ_N]});
  always_ff @(posedge clk) begin
    if (rst) dv_vld[0] <= 1'b0;
    else if (en) dv_vld[0] <= sq_vld[SQ_N];
    if (en) begin
      dv_cplx[0]  <= sq_cplx[SQ_N];
      dv_fault[0] <= sq_a[SQ_N] == '0;
      dv_neg1[0]  <= n1[18] != sq_a[SQ_N][15];
      dv_neg2[0]  <= n2[18] != sq_a[SQ_N][15];
      dv_den[0]   <= qrs_pkg::DEN_W'(sq_a[SQ_N][15] ? -a_ext : a_ext) << 1;
      dv_r1[0]    <= '0;
      dv_r2[0]    <= '0;
      dv_q1[0]    <= {qrs_pkg::NUM_W'(n1[18] ? -n1 : n1), 16'b0};
      dv_q2[0]    <= {qrs_pkg::NUM_W'(n2[18] ? -n2 : n2), 16'b0};
    end
  end

  // restoring divider stages, one quotient bit each for both values
  for (genvar j = 0; j < DV_N; j++) begin : g_dv
    logic [qrs_pkg::DV_REM_W-1:0] s1, s2, dn;
    logic t1, t2;
    always_comb begin
      dn = {1'b0, dv_den[j]};
      s1 = {dv_r1[j][qrs_pkg::DV_REM_W-2:0], dv_q1[j][qrs_pkg::QUO_W-1]};
      s2 = {dv_r2[j][qrs_pkg::DV_REM_W-2:0], dv_q2[j][qrs_pkg::QUO_W-1]};
      t1 = s1 >= dn;
      t2 = s2 >= dn;
    end
    always_ff @(posedge clk) begin
      if (rst) dv_vld[j+1] <= 1'b0;
      else if (en) dv_vld[j+1] <= dv_vld[j];
      if (en) begin
        dv_r1[j+1]    <= t1 ? s1 - dn : s1;
        dv_r2[j+1]    <= t2 ? s2 - dn : s2;
        dv_q1[j+1]    <= {dv_q1[j][qrs_pkg::QUO_W-2:0], t1};
        dv_q2[j+1]    <= {dv_q2[j][qrs_pkg::QUO_W-2:0], t2};
        dv_den[j+1]   <= dv_den[j];
        dv_cplx[j+1]  <= dv_cplx[j];
        dv_fault[j+1] <= dv_fault[j];
        dv_neg1[j+1]  <= dv_neg1[j];
        dv_neg2[j+1]  <= dv_neg2[j];
      end
    end
  end

  // sign, saturate and register the result
  logic [qrs_pkg::QUO_W-1:0] q1, q2;
  logic neg1, neg2, sat1, sat2;
  logic [31:0] v1, v2;
  always_comb begin
    q1   = dv_q1[DV_N];
    q2   = dv_q2[DV_N];
    neg1 = dv_neg1[DV_N] && q1 != '0;
    neg2 = dv_neg2[DV_N] && q2 != '0;
    sat1 = neg1 ? q1 > qrs_pkg::QUO_W'(33'h080000000) : q1 > qrs_pkg::QUO_W'(33'h07FFFFFFF);
    sat2 = neg2 ? q2 > qrs_pkg::QUO_W'(33'h080000000) : q2 > qrs_pkg::QUO_W'(33'h07FFFFFFF);
    v1   = sat1 ? (neg1 ? 32'h80000000 : 32'h7FFFFFFF) : (neg1 ? -q1[31:0] : q1[31:0]);
    v2   = sat2 ? (neg2 ? 32'h80000000 : 32'h7FFFFFFF) : (neg2 ? -q2[31:0] : q2[31:0]);
  end
  always_ff @(posedge clk) begin
    if (rst) result.valid <= 1'b0;
    else if (en) result.valid <= dv_vld[DV_N];
    if (en) begin
      result.first_value  <= dv_fault[DV_N] ? '0 : $signed(v1);
      result.second_value <= dv_fault[DV_N] ? '0 : $signed(v2);
      result.is_complex   <= dv_cplx[DV_N];
      result.divide_fault <= dv_fault[DV_N];
      result.saturated    <= !dv_fault[DV_N] && (sat1 || sat2);
    end
  end
endmodule
